// ===== design/assert_macros.svh =====
// Assertion macros shared by the checker files.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, skipped while reset is asserted.
`define PS2M_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that is also checked during reset.
`define PS2M_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/ps2m_pkg.sv =====
// Package for the PS/2 mouse packet decoder: event codes and fixed constants.
// No dependencies.
`default_nettype none

package ps2m_pkg;

    localparam int unsigned SYNC_BIT = 3;    // always set in a first byte

    typedef enum logic [2:0] {
        EV_MIDDLE_CHANGE = 3'd0,
        EV_RIGHT_PRESS   = 3'd1,
        EV_RIGHT_RELEASE = 3'd2,
        EV_LEFT_PRESS    = 3'd3,
        EV_LEFT_RELEASE  = 3'd4,
        EV_MOVE          = 3'd5
    } t_event_kind;

    typedef logic [1:0] t_byte_idx;

endpackage

`default_nettype wire

// ===== design/ps2m_byte_if.sv =====
// Valid/ready channel carrying one received mouse byte.
// No dependencies.
`default_nettype none

interface ps2m_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

`default_nettype wire

// ===== design/ps2m_pkt_if.sv =====
// Valid/ready channel carrying one decoded mouse packet.
// Depends on ps2m_pkg for the event code type.
`default_nettype none

interface ps2m_pkt_if
    import ps2m_pkg::*;
;
    logic               valid;
    logic               ready;
    logic               left_button;
    logic               right_button;
    logic               middle_button;
    logic               x_overflow;
    logic               y_overflow;
    logic signed [8:0]  move_x;
    logic signed [8:0]  move_y;
    logic [7:0]         scroll_byte;
    t_event_kind        event_kind;

    modport source (
        output valid, output left_button, output right_button, output middle_button,
        output x_overflow, output y_overflow, output move_x, output move_y,
        output scroll_byte, output event_kind, input ready
    );
    modport sink (
        input valid, input left_button, input right_button, input middle_button,
        input x_overflow, input y_overflow, input move_x, input move_y,
        input scroll_byte, input event_kind, output ready
    );
endinterface

`default_nettype wire

// ===== design/ps2_mouse_packet_decoder_unit.sv =====
// PS/2 mouse packet decoder: a packet shows on o_pkt in the cycle after the transfer of its
// last byte; it takes one byte per cycle while o_pkt is not stalled, set by the single
// result register, which reloads in the cycle it is taken.
// Reset (i_rst_n low, synchronous) clears the byte count, previous buttons, scroll mode
// and the output valid; the byte store keeps its contents.
// Depends on ps2m_pkg, ps2m_byte_if and ps2m_pkt_if.
`default_nettype none

module ps2_mouse_packet_decoder_unit
    import ps2m_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_cfg_wr_en,
    input  wire logic   i_cfg_wr_data,
    ps2m_byte_if.sink   i_byte,
    ps2m_pkt_if.source  o_pkt
);

    // Configuration: 1 selects four-byte packets with a scroll byte.
    logic r_scroll_mode;

    // Packet assembly state.
    t_byte_idx  r_byte_idx;
    logic [7:0] r_store [3];        // first, second, third byte
    logic [2:0] r_prev_buttons;     // middle, right, left

    // Result register.
    logic               r_out_valid;
    logic               r_left, r_right, r_middle, r_x_ovf, r_y_ovf;
    logic signed [8:0]  r_move_x, r_move_y;
    logic [7:0]         r_scroll;
    t_event_kind        r_kind;

    logic        in_xfer;
    logic        drop;
    logic        collect;
    logic        complete;
    t_byte_idx   last_idx;
    logic [7:0]  b0, b2, zb;
    t_event_kind n_kind;

    // The result register frees itself in the same cycle it is taken, so a byte
    // can be accepted every cycle while the sink keeps up.
    assign i_byte.ready = !r_out_valid || o_pkt.ready;
    assign in_xfer      = i_byte.valid && i_byte.ready;

    assign last_idx = r_scroll_mode ? 2'd3 : 2'd2;

    // Out of sync: a would-be first byte without bit 3 is thrown away.
    assign drop     = (r_byte_idx == 2'd0) && !i_byte.data_byte[SYNC_BIT];
    // Count beyond the mode's last index (mode dropped mid-packet) also completes.
    assign collect  = !drop && (r_byte_idx < last_idx);
    assign complete = !drop && !collect;

    assign b0 = r_store[0];
    assign b2 = r_scroll_mode ? r_store[2] : i_byte.data_byte;
    assign zb = r_scroll_mode ? i_byte.data_byte : 8'd0;

    // Event class: first button difference in middle, right, left order.
    always_comb begin
        priority if (r_prev_buttons[2] != b0[2]) begin
            n_kind = EV_MIDDLE_CHANGE;
        end else if (r_prev_buttons[1] != b0[1]) begin
            n_kind = r_prev_buttons[1] ? EV_RIGHT_RELEASE : EV_RIGHT_PRESS;
        end else if (r_prev_buttons[0] != b0[0]) begin
            n_kind = r_prev_buttons[0] ? EV_LEFT_RELEASE : EV_LEFT_PRESS;
        end else begin
            n_kind = EV_MOVE;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scroll_mode  <= 1'b0;
            r_byte_idx     <= 2'd0;
            r_prev_buttons <= 3'd0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_scroll_mode <= i_cfg_wr_data;
            end
            if (in_xfer && collect) begin
                r_byte_idx <= r_byte_idx + 2'd1;
            end else if (in_xfer && complete) begin
                r_byte_idx <= 2'd0;
            end
            if (in_xfer && complete) begin
                r_prev_buttons <= b0[2:0];
                r_out_valid    <= 1'b1;
            end else if (o_pkt.ready) begin
                r_out_valid    <= 1'b0;
            end
        end
    end

    // Byte store; collect implies the index is at most two.
    always_ff @(posedge i_clk) begin
        if (in_xfer && collect) begin
            r_store[r_byte_idx] <= i_byte.data_byte;
        end
    end

    // Result payload, loaded on the transfer that completes a packet.
    always_ff @(posedge i_clk) begin
        if (in_xfer && complete) begin
            r_left   <= b0[0];
            r_right  <= b0[1];
            r_middle <= b0[2];
            r_x_ovf  <= b0[6];
            r_y_ovf  <= b0[7];
            r_move_x <= $signed({b0[4], r_store[1]});
            r_move_y <= $signed({b0[5], b2});
            r_scroll <= zb;
            r_kind   <= n_kind;
        end
    end

    assign o_pkt.valid         = r_out_valid;
    assign o_pkt.left_button   = r_left;
    assign o_pkt.right_button  = r_right;
    assign o_pkt.middle_button = r_middle;
    assign o_pkt.x_overflow    = r_x_ovf;
    assign o_pkt.y_overflow    = r_y_ovf;
    assign o_pkt.move_x        = r_move_x;
    assign o_pkt.move_y        = r_move_y;
    assign o_pkt.scroll_byte   = r_scroll;
    assign o_pkt.event_kind    = r_kind;

endmodule

`default_nettype wire

// ===== design/ps2m_checker.sv =====
// Port-level checks for the PS/2 mouse packet decoder, bound to its top level.
// Depends on ps2m_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module ps2m_checker
    import ps2m_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic        out_left,
    input wire logic        out_right,
    input wire logic [8:0]  out_move_x,
    input wire logic [8:0]  out_move_y,
    input wire t_event_kind out_kind
);

    `PS2M_ASSERT_ALWAYS(a_reset_clears_out, i_clk, !i_rst_n |=> !out_valid, "out valid after reset")

    `PS2M_ASSERT(a_ready_when_empty, i_clk, i_rst_n, !out_valid |-> in_ready, "stalled while output empty")

    `PS2M_ASSERT(a_stall_holds, i_clk, i_rst_n, out_valid && !out_ready |=> out_valid && $stable(out_move_x) && $stable(out_move_y) && $stable(out_kind), "stalled packet changed")

    `PS2M_ASSERT(a_kind_matches_buttons, i_clk, i_rst_n, out_valid |-> (out_kind != EV_RIGHT_PRESS || out_right) && (out_kind != EV_RIGHT_RELEASE || !out_right) && (out_kind != EV_LEFT_PRESS || out_left) && (out_kind != EV_LEFT_RELEASE || !out_left), "event class disagrees with buttons")

endmodule

bind ps2_mouse_packet_decoder_unit ps2m_checker u_ps2m_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .in_ready   (i_byte.ready),
    .out_valid  (o_pkt.valid),
    .out_ready  (o_pkt.ready),
    .out_left   (o_pkt.left_button),
    .out_right  (o_pkt.right_button),
    .out_move_x (o_pkt.move_x),
    .out_move_y (o_pkt.move_y),
    .out_kind   (o_pkt.event_kind)
);

`default_nettype wire

// ===== tb/ps2m_decoder_checker.sv =====
// Checker for the PS/2 mouse packet decoder: predicts decoded packets from observed
// byte and config transfers and compares them with the packets the block emits.
// Depends on ps2m_pkg, ps2m_byte_if and ps2m_pkt_if.
module ps2m_decoder_checker
    import ps2m_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_cfg_wr_en,
    input  wire logic i_cfg_wr_data,
    ps2m_byte_if      byte_mon,
    ps2m_pkt_if       pkt_mon,
    output int        o_fail_count,
    output int        o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic              left_btn;
        logic              right_btn;
        logic              middle_btn;
        logic              x_ovf;
        logic              y_ovf;
        logic signed [8:0] dx;
        logic signed [8:0] dy;
        logic [7:0]        scroll;
        t_event_kind       kind;
    } t_mouse_pkt;

    // shadow decoder state
    logic       scroll_on;
    t_byte_idx  byte_idx;
    logic [7:0] byte_store [3];
    logic [2:0] prev_btn;    // middle, right, left

    t_mouse_pkt expected_pkts[$];
    int         fail_total = 0;

    task automatic decode_byte(input logic [7:0] b);
        t_mouse_pkt p;
        t_byte_idx  last;
        logic [7:0] third;
        logic [2:0] btn;
        last = scroll_on ? 2'd3 : 2'd2;
        if (byte_idx == 2'd0 && !b[SYNC_BIT]) begin
            return;    // out of sync, dropped
        end
        if (byte_idx < last) begin
            byte_store[byte_idx] = b;
            byte_idx = byte_idx + 2'd1;
            return;
        end
        // packet complete; in three-byte mode this byte is Y even if a third was stored
        third = scroll_on ? byte_store[2] : b;
        btn = byte_store[0][2:0];
        byte_idx = 2'd0;
        p.left_btn   = btn[0];
        p.right_btn  = btn[1];
        p.middle_btn = btn[2];
        p.x_ovf      = byte_store[0][6];
        p.y_ovf      = byte_store[0][7];
        p.dx         = {byte_store[0][4], byte_store[1]};
        p.dy         = {byte_store[0][5], third};
        p.scroll     = scroll_on ? b : 8'h00;
        if (prev_btn[2] != btn[2]) begin
            p.kind = EV_MIDDLE_CHANGE;
        end else if (prev_btn[1] != btn[1]) begin
            p.kind = prev_btn[1] ? EV_RIGHT_RELEASE : EV_RIGHT_PRESS;
        end else if (prev_btn[0] != btn[0]) begin
            p.kind = prev_btn[0] ? EV_LEFT_RELEASE : EV_LEFT_PRESS;
        end else begin
            p.kind = EV_MOVE;
        end
        prev_btn = btn;
        expected_pkts.push_back(p);
    endtask

    task automatic check_packet();
        t_mouse_pkt want;
        t_mouse_pkt got;
        got.left_btn   = pkt_mon.left_button;
        got.right_btn  = pkt_mon.right_button;
        got.middle_btn = pkt_mon.middle_button;
        got.x_ovf      = pkt_mon.x_overflow;
        got.y_ovf      = pkt_mon.y_overflow;
        got.dx         = pkt_mon.move_x;
        got.dy         = pkt_mon.move_y;
        got.scroll     = pkt_mon.scroll_byte;
        got.kind       = pkt_mon.event_kind;
        if (expected_pkts.size() == 0) begin
            fail_total++;
            if (fail_total <= 10) begin
                $display("%0t: packet with none expected: L%b R%b M%b dx %0d dy %0d kind %0d",
                         $time, got.left_btn, got.right_btn, got.middle_btn,
                         got.dx, got.dy, got.kind);
            end
            return;
        end
        want = expected_pkts.pop_front();
        if (got.left_btn !== want.left_btn || got.right_btn !== want.right_btn ||
            got.middle_btn !== want.middle_btn || got.x_ovf !== want.x_ovf ||
            got.y_ovf !== want.y_ovf || got.dx !== want.dx || got.dy !== want.dy ||
            got.scroll !== want.scroll || got.kind !== want.kind) begin
            fail_total++;
            if (fail_total <= 10) begin
                $display("%0t: packet mismatch", $time);
                $display("  want L%b R%b M%b xo%b yo%b dx %0d dy %0d scroll %h kind %0d",
                         want.left_btn, want.right_btn, want.middle_btn, want.x_ovf,
                         want.y_ovf, want.dx, want.dy, want.scroll, want.kind);
                $display("  got  L%b R%b M%b xo%b yo%b dx %0d dy %0d scroll %h kind %0d",
                         got.left_btn, got.right_btn, got.middle_btn, got.x_ovf,
                         got.y_ovf, got.dx, got.dy, got.scroll, got.kind);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            scroll_on = 1'b0;
            byte_idx  = 2'd0;
            prev_btn  = 3'd0;
            expected_pkts.delete();
        end else begin
            if (pkt_mon.valid && pkt_mon.ready) begin
                check_packet();
            end
            if (byte_mon.valid && byte_mon.ready) begin
                decode_byte(byte_mon.data_byte);
            end
            if (i_cfg_wr_en) begin
                scroll_on = i_cfg_wr_data;
            end
        end
        o_pending    <= expected_pkts.size();
        o_fail_count <= fail_total;
    end

endmodule

// ===== tb/tb.sv =====
// Top of the PS/2 mouse packet decoder testbench: clock, reset, byte stimulus,
// packet back-pressure, scroll mode writes, watchdog and verdict.
// Depends on ps2m_pkg, both channel interfaces, the decoder and ps2m_decoder_checker.
module tb
    import ps2m_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES = 300;    // long receiver hold-off, fills the block
    localparam int IDLE_LIMIT  = 2000;   // watchdog: cycles without any transfer
    localparam int PHASES      = 8;
    localparam int PHASE_BYTES = 72;     // well-formed packet bytes per random phase

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_wr_en;
    logic cfg_wr_data;
    int   fail_count;
    int   pending;

    // shared between the byte sender and the packet receiver
    logic tx_calm  = 1'b0;   // sender offers back to back
    logic rx_calm  = 1'b0;   // receiver stalls only for a requested hold-off
    logic hold_req = 1'b0;   // ask receiver for one long hold-off
    logic scroll_sel;        // mode the sender builds packets for

    ps2m_byte_if byte_ch ();
    ps2m_pkt_if  pkt_ch ();

    ps2_mouse_packet_decoder_unit dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_byte        (byte_ch),
        .o_pkt         (pkt_ch)
    );

    ps2m_decoder_checker chk (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .byte_mon      (byte_ch),
        .pkt_mon       (pkt_ch),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // 12 ns period
    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Idle length: mostly short, now and then a long one.
    function automatic int pick_idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return $urandom_range(1, 3);
        end else if (r < 95) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // Offer one byte from a falling edge, wait for its transfer, then maybe idle.
    // Leaves valid high when no gap is drawn, so back-to-back bytes never glitch it.
    // Returns at a falling edge.
    task automatic put_byte(input logic [7:0] b);
        int gap;
        byte_ch.valid     <= 1'b1;
        byte_ch.data_byte <= b;
        @(posedge clk);
        while (!byte_ch.ready) begin
            @(posedge clk);
        end
        @(negedge clk);
        gap = (!tx_calm && $urandom_range(0, 99) < 40) ? pick_idle_len() : 0;
        if (gap > 0) begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // Write scroll mode once the block is quiet: every expected packet out, then a
    // further wait, since a dropped or stored byte may still be in flight.
    task automatic set_scroll_mode(input logic mode);
        byte_ch.valid <= 1'b0;
        while (pending != 0) begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mode;
        scroll_sel  = mode;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Packet receiver: random stall stretches, plus one long hold-off on request.
    initial begin
        int   stall_left;
        logic hold_seen;
        stall_left   = 0;
        hold_seen    = 1'b0;
        pkt_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req && !hold_seen) begin
                hold_seen  = 1'b1;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                pkt_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                pkt_ch.ready <= 1'b1;
                if (!rx_calm && $urandom_range(0, 99) < 20) begin
                    stall_left = pick_idle_len();
                end
            end
        end
    end

    // Watchdog: ends a run in which nothing moves for too long.
    int idle_cycles = 0;
    always @(posedge clk) begin
        if ((byte_ch.valid && byte_ch.ready) || (pkt_ch.valid && pkt_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Byte stimulus and verdict.
    initial begin
        logic [7:0] first;
        int         sent;
        int         pkt_len;
        rst_n             = 1'b0;
        cfg_wr_en         = 1'b0;
        cfg_wr_data       = 1'b0;
        scroll_sel        = 1'b0;
        byte_ch.valid     = 1'b0;
        byte_ch.data_byte = 8'h00;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // ---- directed part, three-byte mode from reset ----
        // lost sync: bit 3 clear while waiting for a first byte, both dropped
        put_byte(8'h00);
        put_byte(8'hF7);
        // plain movement, all zero
        put_byte(8'h08); put_byte(8'h00); put_byte(8'h00);
        // right press, both sign bits set, dx = -255, dy = -1
        put_byte(8'h3A); put_byte(8'h01); put_byte(8'hFF);
        // right release, both overflow flags
        put_byte(8'hC8); put_byte(8'hFF); put_byte(8'h80);
        // left press
        put_byte(8'h09); put_byte(8'h7F); put_byte(8'h00);
        // left release
        put_byte(8'h08); put_byte(8'h80); put_byte(8'h7F);

        // four-byte mode, every bit set: middle change, scroll byte 0xFF
        set_scroll_mode(1'b1);
        put_byte(8'hFF); put_byte(8'hFF); put_byte(8'hFF); put_byte(8'hFF);

        // three bytes held, then back to three-byte mode: next byte is the Y byte
        put_byte(8'h2C); put_byte(8'h55); put_byte(8'hAA);
        set_scroll_mode(1'b0);
        put_byte(8'h33);

        // two bytes held, then four-byte mode: collection runs on to four bytes;
        // the later bytes have bit 3 clear and still count since sync is held
        put_byte(8'h1B); put_byte(8'h80);
        set_scroll_mode(1'b1);
        put_byte(8'h12); put_byte(8'h00);

        // ---- random part ----
        // Mostly well-formed packets with random content; some stray bytes knock
        // the framing off so resync gets exercised. Phases end mid-packet at random,
        // so mode switches also land with bytes held.
        for (int ph = 0; ph < PHASES; ph++) begin
            set_scroll_mode(ph < 2 ? ph[0] : 1'($urandom_range(0, 1)));
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);
            if (ph == 2) begin
                // sender keeps offering while the receiver sits out a long stretch
                hold_req = 1'b1;
                tx_calm  = 1'b1;
            end
            sent = 0;
            while (sent < PHASE_BYTES) begin
                if ($urandom_range(0, 99) < 12) begin
                    put_byte(8'($urandom_range(0, 255)));    // stray byte, not counted
                end else begin
                    first = 8'($urandom_range(0, 255));
                    first[SYNC_BIT] = 1'b1;
                    put_byte(first);
                    pkt_len = scroll_sel ? 4 : 3;
                    for (int k = 1; k < pkt_len; k++) begin
                        put_byte(8'($urandom_range(0, 255)));
                    end
                    sent += pkt_len;
                end
            end
        end

        // drain: wait for every expected packet, then let the block settle before the verdict
        byte_ch.valid <= 1'b0;
        tx_calm = 1'b1;
        while (pending != 0) begin
            @(negedge clk);
        end
        repeat (10) @(negedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/ps2m_pkg.sv
design/ps2m_byte_if.sv
design/ps2m_pkt_if.sv
design/ps2_mouse_packet_decoder_unit.sv
design/ps2m_checker.sv
tb/ps2m_decoder_checker.sv
tb/tb.sv
